@@ rtl/oriented_plane_normal_core_defines.svh @@
// assertion macros shared by the plane normal rtl
`ifndef ORIENTED_PLANE_NORMAL_CORE_DEFINES_SVH
`define ORIENTED_PLANE_NORMAL_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define OPN_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define OPN_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/opn_pkg.sv @@
// widths, codes and bus types of the plane normal datapath
package opn_pkg;

    localparam int PT_W     = 32;           // Q16.16 point component
    localparam int EDGE_W   = PT_W + 1;     // exact edge difference
    localparam int MAG_W    = PT_W - 1;     // edge magnitude after range halving
    localparam int SQ_W     = 2 * MAG_W;    // squared magnitude
    localparam int SUM_W    = 64;           // sum of three squares
    localparam int Q_W      = 31;           // unit magnitude, 0 .. 2^30
    localparam int NUM_BITS = Q_W;          // one search step per quotient bit
    localparam int REM_SH   = 2 * Q_W;      // scale of m^2 in the remainder
    localparam int R_W      = 132;          // signed search remainder
    localparam int T_W      = 97;           // signed running s*(2q-1)
    localparam int LANES    = 6;            // x, y and z components of both edge vectors
    localparam int FRAC_W   = 30;           // Q2.30 fraction bits
    localparam int OUT_W    = 32;           // normal component
    localparam int RQ_W     = SUM_W - FRAC_W;
    localparam int DOT_W    = OUT_W + EDGE_W;
    localparam int DSUM_W   = DOT_W + 2;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 2;
    localparam int THR_W    = 31;

    localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_W;
    localparam logic signed [OUT_W-1:0] N_MAX = OUT_W'(Q_ONE);

    // orientation modes
    localparam logic [MODE_W-1:0] MODE_POINT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_VECTOR = 2'd2;

    // register select, taken from paddr bit 2
    localparam logic REG_ORIENT = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    typedef logic [LANES-1:0][SQ_W-1:0]  t_m2_bus;
    typedef logic [1:0][SUM_W-1:0]       t_sum_bus;
    typedef logic [LANES-1:0][Q_W-1:0]   t_q_bus;

    // payload that rides alongside the unit search
    typedef struct packed {
        logic [LANES-1:0]         sgn;
        logic [1:0]               s_zero;
        logic [2:0][EDGE_W-1:0]   dir;
    } t_side;

endpackage

@@ rtl/opn_unitize.sv @@
// pipelined bit-serial search for the rounded unit components of both edges
`include "oriented_plane_normal_core_defines.svh"

module opn_unitize (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  opn_pkg::t_m2_bus  i_m2,
    input  opn_pkg::t_sum_bus i_s,
    input  opn_pkg::t_side    i_side,
    output logic             o_valid,
    output opn_pkg::t_q_bus   o_q,
    output opn_pkg::t_side    o_side
);
    import opn_pkg::*;

    // per stage: remainder m^2*2^62 - (2q-1)^2*s, running s*(2q-1), quotient
    logic signed [R_W-1:0] r_rem [0:NUM_BITS][LANES];
    logic signed [T_W-1:0] r_t   [0:NUM_BITS][LANES];
    logic [Q_W-1:0]        r_q   [0:NUM_BITS][LANES];
    logic [SUM_W-1:0]      r_s   [0:NUM_BITS][2];
    t_side                 r_side[0:NUM_BITS];
    logic [NUM_BITS:0]     r_vld;

    // valid bits shift with the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NUM_BITS-1:0], i_valid};
        end
    end

    // load: q = 0, so 2q-1 = -1
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < LANES; j++) begin
                r_rem[0][j] <= $signed({{(R_W-SQ_W-REM_SH){1'b0}}, i_m2[j], {REM_SH{1'b0}}})
                    - $signed({{(R_W-SUM_W){1'b0}}, i_s[(j < 3) ? 1'b0 : 1'b1]});
                r_t[0][j]   <= -$signed({{(T_W-SUM_W){1'b0}}, i_s[(j < 3) ? 1'b0 : 1'b1]});
                r_q[0][j]   <= '0;
            end
            r_s[0][0] <= i_s[0];
            r_s[0][1] <= i_s[1];
            r_side[0] <= i_side;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar k = 1; k <= NUM_BITS; k++) begin : g_bit
        localparam int B = NUM_BITS - k;

        logic signed [R_W-1:0] c_rem [LANES];
        logic signed [T_W-1:0] c_t   [LANES];
        logic [LANES-1:0]      c_ok;

        // trial: raise 2q-1 by 2^(b+1); keep it if the remainder stays non-negative and q's msb is not set
        always_comb begin
            for (int j = 0; j < LANES; j++) begin
                c_rem[j] = r_rem[k-1][j]
                    - ($signed({{(R_W-T_W){r_t[k-1][j][T_W-1]}}, r_t[k-1][j]}) <<< (B + 2))
                    - $signed({{(R_W-SUM_W){1'b0}}, r_s[k-1][(j < 3) ? 1'b0 : 1'b1]}
                              << (2 * B + 2));
                c_t[j]   = r_t[k-1][j]
                    + $signed({{(T_W-SUM_W){1'b0}}, r_s[k-1][(j < 3) ? 1'b0 : 1'b1]}
                              << (B + 1));
                c_ok[j]  = !c_rem[j][R_W-1] && ((B == Q_W - 1) || !r_q[k-1][j][Q_W-1]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int j = 0; j < LANES; j++) begin
                    if (c_ok[j]) begin
                        r_rem[k][j] <= c_rem[j];
                        r_t[k][j]   <= c_t[j];
                        r_q[k][j]   <= r_q[k-1][j] | (Q_W'(1) << B);
                    end else begin
                        r_rem[k][j] <= r_rem[k-1][j];
                        r_t[k][j]   <= r_t[k-1][j];
                        r_q[k][j]   <= r_q[k-1][j];
                    end
                end
                r_s[k][0] <= r_s[k-1][0];
                r_s[k][1] <= r_s[k-1][1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // result
    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            o_q[j] = r_q[NUM_BITS][j];
        end
    end
    assign o_valid = r_vld[NUM_BITS];
    assign o_side  = r_side[NUM_BITS];

    // checks
    `OPN_ASSERT_IMP(a_q_range, i_clk, i_rst_n, o_valid, (o_q[0] <= Q_ONE) && (o_q[1] <= Q_ONE) && (o_q[2] <= Q_ONE) && (o_q[3] <= Q_ONE) && (o_q[4] <= Q_ONE) && (o_q[5] <= Q_ONE), "unit magnitude above one")
    `OPN_ASSERT_NXT(a_hold_valid, i_clk, i_rst_n, !i_en, $stable(o_valid), "search output moved while frozen")
    `OPN_ASSERT_NXT(a_bubble, i_clk, i_rst_n, i_en && !r_vld[NUM_BITS-1], !o_valid, "bubble lost in search")

endmodule

@@ rtl/oriented_plane_normal_core.sv @@
// top level: oriented unit normal of the plane through three points
//
// Input channel: i_valid / o_stall with three Q16.16 points and a direction
// operand; a beat is taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with the Q2.30 normal and o_normal_valid.
// Registers over the APB-style port: orient_mode at 0x0, zero_threshold at
// 0x4; write them only while no beat is in flight.
// One beat enters every cycle while o_stall is low. The depth is set by the
// 32-stage bit search (a load stage and one stage per quotient bit) that forms
// each rounded unit edge component, plus 12 stages of edge, square, cross
// product, rounding, length and orientation arithmetic.
// Reset (synchronous, active low) empties the pipeline and sets orient_mode
// to 0 and zero_threshold to 1.
// While the receiver stalls a waiting result, the whole pipeline holds and
// o_stall is raised; nothing is dropped or repeated, and the input side is
// freed again the cycle the result is taken.
`include "oriented_plane_normal_core_defines.svh"

module oriented_plane_normal_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [opn_pkg::PT_W-1:0]     i_p1_x,
    input  logic signed [opn_pkg::PT_W-1:0]     i_p1_y,
    input  logic signed [opn_pkg::PT_W-1:0]     i_p1_z,
    input  logic signed [opn_pkg::PT_W-1:0]     i_p2_x,
    input  logic signed [opn_pkg::PT_W-1:0]     i_p2_y,
    input  logic signed [opn_pkg::PT_W-1:0]     i_p2_z,
    input  logic signed [opn_pkg::PT_W-1:0]     i_p3_x,
    input  logic signed [opn_pkg::PT_W-1:0]     i_p3_y,
    input  logic signed [opn_pkg::PT_W-1:0]     i_p3_z,
    input  logic signed [opn_pkg::PT_W-1:0]     i_dir_x,
    input  logic signed [opn_pkg::PT_W-1:0]     i_dir_y,
    input  logic signed [opn_pkg::PT_W-1:0]     i_dir_z,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [opn_pkg::OUT_W-1:0]    o_normal_x,
    output logic signed [opn_pkg::OUT_W-1:0]    o_normal_y,
    output logic signed [opn_pkg::OUT_W-1:0]    o_normal_z,
    output logic                                o_normal_valid,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [opn_pkg::ADDR_W-1:0]          paddr,
    input  logic [opn_pkg::DATA_W-1:0]          pwdata,
    output logic [opn_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);
    import opn_pkg::*;

    // configuration registers
    logic [MODE_W-1:0] r_mode;
    logic [THR_W-1:0]  r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
            r_thr  <= THR_W'(1);
        end else if (psel && penable && pwrite) begin
            unique case (paddr[ADDR_W-1])
                REG_ORIENT: r_mode <= pwdata[MODE_W-1:0];
                REG_THRESH: r_thr  <= pwdata[THR_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[ADDR_W-1])
            REG_ORIENT: prdata = DATA_W'(r_mode);
            REG_THRESH: prdata = DATA_W'(r_thr);
        endcase
    end
    assign pready = 1'b1;

    // global advance: everything holds while a finished beat is stalled
    logic r_out_vld;
    logic w_en;
    assign w_en    = !(r_out_vld && i_stall);
    assign o_stall = r_out_vld && i_stall;

    logic signed [PT_W-1:0] w_p1 [3];
    logic signed [PT_W-1:0] w_p2 [3];
    logic signed [PT_W-1:0] w_p3 [3];
    logic signed [PT_W-1:0] w_dir[3];
    assign w_p1  = '{i_p1_x, i_p1_y, i_p1_z};
    assign w_p2  = '{i_p2_x, i_p2_y, i_p2_z};
    assign w_p3  = '{i_p3_x, i_p3_y, i_p3_z};
    assign w_dir = '{i_dir_x, i_dir_y, i_dir_z};

    // stage a: edges and direction vector
    logic                    r_a_vld;
    logic signed [EDGE_W-1:0] r_a_e [LANES];
    logic signed [EDGE_W-1:0] r_a_d [3];
    logic signed [EDGE_W-1:0] n_a_e [LANES];
    logic signed [EDGE_W-1:0] n_a_d [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_a_e[i]     = $signed({w_p2[i][PT_W-1], w_p2[i]})
                         - $signed({w_p1[i][PT_W-1], w_p1[i]});
            n_a_e[i + 3] = $signed({w_p3[i][PT_W-1], w_p3[i]})
                         - $signed({w_p1[i][PT_W-1], w_p1[i]});
            if (r_mode == MODE_POINT) begin
                n_a_d[i] = $signed({w_dir[i][PT_W-1], w_dir[i]})
                         - $signed({w_p1[i][PT_W-1], w_p1[i]});
            end else begin
                n_a_d[i] = $signed({w_dir[i][PT_W-1], w_dir[i]});
            end
        end
    end

    // stage b: magnitudes, halved when any component of the edge reaches 2^31
    logic                     r_b_vld;
    logic [MAG_W-1:0]         r_b_m   [LANES];
    logic [LANES-1:0]         r_b_sgn;
    logic signed [EDGE_W-1:0] r_b_d   [3];
    logic [EDGE_W-1:0]        w_abs   [LANES];
    logic [1:0]               w_big;
    logic [MAG_W-1:0]         n_b_m   [LANES];

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            w_abs[j] = r_a_e[j][EDGE_W-1] ? EDGE_W'(-r_a_e[j]) : EDGE_W'(r_a_e[j]);
        end
        w_big[0] = w_abs[0][MAG_W] | w_abs[1][MAG_W] | w_abs[2][MAG_W];
        w_big[1] = w_abs[3][MAG_W] | w_abs[4][MAG_W] | w_abs[5][MAG_W];
        for (int j = 0; j < LANES; j++) begin
            n_b_m[j] = w_big[(j < 3) ? 1'b0 : 1'b1] ? w_abs[j][MAG_W:1]
                                                    : w_abs[j][MAG_W-1:0];
        end
    end

    // stage c: squares
    logic                     r_c_vld;
    t_m2_bus                  r_c_m2;
    logic [LANES-1:0]         r_c_sgn;
    logic signed [EDGE_W-1:0] r_c_d [3];

    // stage d: sums of squares and side payload
    logic     r_d_vld;
    t_m2_bus  r_d_m2;
    t_sum_bus r_d_s;
    t_side    r_d_side;
    t_sum_bus n_d_s;
    t_side    n_d_side;

    always_comb begin
        for (int e = 0; e < 2; e++) begin
            n_d_s[e] = SUM_W'(r_c_m2[3*e]) + SUM_W'(r_c_m2[3*e + 1])
                     + SUM_W'(r_c_m2[3*e + 2]);
            n_d_side.s_zero[e] = ~|{r_c_m2[3*e], r_c_m2[3*e + 1], r_c_m2[3*e + 2]};
        end
        n_d_side.sgn = r_c_sgn;
        for (int i = 0; i < 3; i++) begin
            n_d_side.dir[i] = r_c_d[i];
        end
    end

    // rounded unit components
    logic   w_u_vld;
    t_q_bus w_u_q;
    t_side  w_u_side;

    opn_unitize u_unitize (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_d_vld),
        .i_m2    (r_d_m2),
        .i_s     (r_d_s),
        .i_side  (r_d_side),
        .o_valid (w_u_vld),
        .o_q     (w_u_q),
        .o_side  (w_u_side)
    );

    // stage e: signed unit vectors, zero for a zero-length edge
    logic                     r_e_vld;
    logic signed [OUT_W-1:0]  r_e_u [LANES];
    logic signed [EDGE_W-1:0] r_e_d [3];
    logic signed [OUT_W-1:0]  n_e_u [LANES];

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            if (w_u_side.s_zero[(j < 3) ? 1'b0 : 1'b1]) begin
                n_e_u[j] = '0;
            end else if (w_u_side.sgn[j]) begin
                n_e_u[j] = -$signed({1'b0, w_u_q[j]});
            end else begin
                n_e_u[j] = $signed({1'b0, w_u_q[j]});
            end
        end
    end

    // stage f: cross products, Q4.60
    logic                     r_f_vld;
    logic signed [SUM_W-1:0]  r_f_p [LANES];
    logic signed [EDGE_W-1:0] r_f_d [3];

    // stage g: cross differences
    logic                     r_g_vld;
    logic signed [SUM_W-1:0]  r_g_c [3];
    logic signed [EDGE_W-1:0] r_g_d [3];

    // stage h: round magnitude to Q2.30
    logic                     r_h_vld;
    logic [RQ_W-1:0]          r_h_r   [3];
    logic [2:0]               r_h_neg;
    logic signed [EDGE_W-1:0] r_h_d   [3];
    logic [SUM_W-1:0]         w_mag   [3];
    logic [SUM_W-1:0]         w_rnd   [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = r_g_c[i][SUM_W-1] ? SUM_W'(-r_g_c[i]) : SUM_W'(r_g_c[i]);
            w_rnd[i] = w_mag[i] + (SUM_W'(1) << (FRAC_W - 1));
        end
    end

    // stage i: saturate and restore sign
    logic                     r_i_vld;
    logic signed [OUT_W-1:0]  r_i_n [3];
    logic signed [EDGE_W-1:0] r_i_d [3];
    logic [Q_W-1:0]           w_sat [3];
    logic signed [OUT_W-1:0]  n_i_n [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sat[i] = (r_h_r[i] > RQ_W'(Q_ONE)) ? Q_ONE : r_h_r[i][Q_W-1:0];
            n_i_n[i] = r_h_neg[i] ? -$signed({1'b0, w_sat[i]}) : $signed({1'b0, w_sat[i]});
        end
    end

    // stage j: squares, direction products, threshold square
    logic                    r_j_vld;
    logic signed [SUM_W-1:0] r_j_sq  [3];
    logic signed [DOT_W-1:0] r_j_dot [3];
    logic signed [OUT_W-1:0] r_j_n   [3];
    logic [SQ_W-1:0]         r_j_thr2;

    // stage k: length and dot sums
    logic                     r_k_vld;
    logic [SUM_W-1:0]         r_k_len2;
    logic signed [DSUM_W-1:0] r_k_dot;
    logic signed [OUT_W-1:0]  r_k_n [3];
    logic [SQ_W-1:0]          r_k_thr2;

    // output stage: validity, orientation flip
    logic                    r_out_nv;
    logic signed [OUT_W-1:0] r_out_n [3];
    logic                    w_valid;
    logic                    w_flip;

    always_comb begin
        w_valid = r_k_len2 >= SUM_W'(r_k_thr2);
        w_flip  = w_valid && ((r_mode == MODE_POINT) || (r_mode == MODE_VECTOR))
                  && r_k_dot[DSUM_W-1];
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
            r_e_vld   <= 1'b0;
            r_f_vld   <= 1'b0;
            r_g_vld   <= 1'b0;
            r_h_vld   <= 1'b0;
            r_i_vld   <= 1'b0;
            r_j_vld   <= 1'b0;
            r_k_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld   <= i_valid;
            r_b_vld   <= r_a_vld;
            r_c_vld   <= r_b_vld;
            r_d_vld   <= r_c_vld;
            r_e_vld   <= w_u_vld;
            r_f_vld   <= r_e_vld;
            r_g_vld   <= r_f_vld;
            r_h_vld   <= r_g_vld;
            r_i_vld   <= r_h_vld;
            r_j_vld   <= r_i_vld;
            r_k_vld   <= r_j_vld;
            r_out_vld <= r_k_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < LANES; j++) begin
                r_a_e[j]   <= n_a_e[j];
                r_b_m[j]   <= n_b_m[j];
                r_b_sgn[j] <= r_a_e[j][EDGE_W-1];
                r_c_m2[j]  <= r_b_m[j] * r_b_m[j];
                r_e_u[j]   <= n_e_u[j];
            end
            r_c_sgn  <= r_b_sgn;
            r_d_m2   <= r_c_m2;
            r_d_s    <= n_d_s;
            r_d_side <= n_d_side;

            r_f_p[0] <= r_e_u[1] * r_e_u[5];
            r_f_p[1] <= r_e_u[2] * r_e_u[4];
            r_f_p[2] <= r_e_u[2] * r_e_u[3];
            r_f_p[3] <= r_e_u[0] * r_e_u[5];
            r_f_p[4] <= r_e_u[0] * r_e_u[4];
            r_f_p[5] <= r_e_u[1] * r_e_u[3];

            for (int i = 0; i < 3; i++) begin
                r_a_d[i]   <= n_a_d[i];
                r_b_d[i]   <= r_a_d[i];
                r_c_d[i]   <= r_b_d[i];
                r_e_d[i]   <= $signed(w_u_side.dir[i]);
                r_f_d[i]   <= r_e_d[i];
                r_g_c[i]   <= r_f_p[2*i] - r_f_p[2*i + 1];
                r_g_d[i]   <= r_f_d[i];
                r_h_r[i]   <= w_rnd[i][SUM_W-1:FRAC_W];
                r_h_neg[i] <= r_g_c[i][SUM_W-1];
                r_h_d[i]   <= r_g_d[i];
                r_i_n[i]   <= n_i_n[i];
                r_i_d[i]   <= r_h_d[i];
                r_j_sq[i]  <= r_i_n[i] * r_i_n[i];
                r_j_dot[i] <= r_i_n[i] * r_i_d[i];
                r_j_n[i]   <= r_i_n[i];
                r_k_n[i]   <= r_j_n[i];
                r_out_n[i] <= w_flip ? -r_k_n[i] : r_k_n[i];
            end
            r_j_thr2 <= r_thr * r_thr;

            r_k_len2 <= $unsigned(r_j_sq[0]) + $unsigned(r_j_sq[1]) + $unsigned(r_j_sq[2]);
            r_k_dot  <= DSUM_W'(r_j_dot[0]) + DSUM_W'(r_j_dot[1]) + DSUM_W'(r_j_dot[2]);
            r_k_thr2 <= r_j_thr2;
            r_out_nv <= w_valid;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_normal_x     = r_out_n[0];
    assign o_normal_y     = r_out_n[1];
    assign o_normal_z     = r_out_n[2];
    assign o_normal_valid = r_out_nv;

    // checks
    `OPN_ASSERT_IMP(a_out_range, i_clk, i_rst_n, o_valid, (o_normal_x <= N_MAX) && (o_normal_x >= -N_MAX) && (o_normal_y <= N_MAX) && (o_normal_y >= -N_MAX) && (o_normal_z <= N_MAX) && (o_normal_z >= -N_MAX), "normal component out of range")
    `OPN_ASSERT_IMP(a_zero_not_valid, i_clk, i_rst_n, o_valid && (o_normal_x == 0) && (o_normal_y == 0) && (o_normal_z == 0) && (r_thr != 0), !o_normal_valid, "zero normal flagged valid")
    `OPN_ASSERT_NXT(a_freeze, i_clk, i_rst_n, !w_en, $stable(r_k_vld), "pipeline moved while stalled")

endmodule
